// File: design/bkht_pkg.sv
// Package with the types, widths and constants of the bucketed key/handle table.
`timescale 1ns / 1ps
package bkht_pkg;

	localparam int BUCKET_COUNT         = 256;
	localparam int BUCKET_BITS          = 8;
	localparam int SLOTS_PER_BUCKET_DEF = 32;

	localparam int REQ_W    = 2;
	localparam int KEY_W    = 31;
	localparam int HANDLE_W = 16;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 14;
	localparam int HASH_W   = 32;

	localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811C9DC5;
	localparam logic [HASH_W-1:0] FNV_PRIME = 32'h01000193;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_FIND   = 2'd1,
		REQ_REMOVE = 2'd2
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_DONE = 2'd0,
		STATUS_MISS = 2'd1,
		STATUS_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH,
		ST_FILL_RD,
		ST_FILL,
		ST_SCAN,
		ST_LAST_RD,
		ST_MOVE,
		ST_DONE
	} state_t;

endpackage

// File: design/bkht_req_if.sv
// Request channel interface of the bucketed key/handle table.
`timescale 1ns / 1ps
interface bkht_req_if import bkht_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [REQ_W-1:0]    req_type;
	logic [KEY_W-1:0]    conn_key;
	logic [HANDLE_W-1:0] conn_handle;

	modport source (output valid, output req_type, output conn_key, output conn_handle,
		input ready);
	modport sink (input valid, input req_type, input conn_key, input conn_handle,
		output ready);
endinterface

// File: design/bkht_rsp_if.sv
// Response channel interface of the bucketed key/handle table.
`timescale 1ns / 1ps
interface bkht_rsp_if import bkht_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] found_handle;
	logic [COUNT_W-1:0]  entry_count;

	modport source (output valid, output status, output found_handle, output entry_count,
		input ready);
	modport sink (input valid, input status, input found_handle, input entry_count,
		output ready);
endinterface

// File: design/bkht_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module bkht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/bucketed_key_handle_table.sv
// Top level of the bucketed key/handle table: hash, bucket fill memory and entry memory.
//
//   channel  direction  fields
//   req      in         req_type, conn_key, conn_handle
//   rsp      out        status, found_handle, entry_count
//
// One request is handled at a time. The FNV-1a hash runs on one multiplier, a key byte at a time,
// followed by a read of the bucket fill memory.
// Find and remove scan the bucket's entries in the entry memory one slot per cycle; when a remove
// hits an entry other than the last, the last entry of the bucket moves into the freed slot.
// Reset clears the fill valid bits at once; the entry memory is never cleared.
// A response waits in its output register while the next request is taken.
`timescale 1ns / 1ps
module bucketed_key_handle_table import bkht_pkg::*; #(
	parameter int SLOTS_PER_BUCKET = SLOTS_PER_BUCKET_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	bkht_req_if.sink   req,
	bkht_rsp_if.source rsp
);

	localparam int SW    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
	localparam int FW    = $clog2(SLOTS_PER_BUCKET + 1);
	localparam int AW    = BUCKET_BITS + SW;
	localparam int DEPTH = BUCKET_COUNT << SW;
	localparam int TW    = $clog2(BUCKET_COUNT * SLOTS_PER_BUCKET + 1);
	localparam int EW    = KEY_W + HANDLE_W;

	state_t state_q, state_d;

	logic [REQ_W-1:0]       req_q;
	logic [KEY_W-1:0]       key_q;
	logic [HANDLE_W-1:0]    handle_q;
	logic [HASH_W-1:0]      hash_q;
	logic [1:0]             round_q;
	logic [FW-1:0]          fill_q;
	logic [FW-1:0]          scan_idx_q;
	logic [FW-1:0]          pos_q;
	logic                   rd_valid_s1;
	logic [FW-1:0]          rd_idx_s1;
	logic [TW-1:0]          total_q;
	status_t                res_status_q;
	logic [HANDLE_W-1:0]    res_handle_q;
	logic [BUCKET_COUNT-1:0] fill_valid_q;

	logic                   out_valid_q;
	logic [STATUS_W-1:0]    out_status_q;
	logic [HANDLE_W-1:0]    out_handle_q;
	logic [COUNT_W-1:0]     out_count_q;

	logic [BUCKET_BITS-1:0] bucket;
	logic [HASH_W-1:0]      key_word;
	logic [7:0]             key_byte;
	logic [HASH_W-1:0]      hash_mix;
	logic [FW-1:0]          fill_rd;
	logic [FW-1:0]          fill_cur;
	logic [FW-1:0]          last_slot;
	logic [31:0]            total_ext;

	logic                   fill_we;
	logic [FW-1:0]          fill_wdata;
	logic                   ent_we;
	logic [AW-1:0]          ent_waddr;
	logic [EW-1:0]          ent_wdata;
	logic [AW-1:0]          ent_raddr;
	logic [EW-1:0]          ent_rdata;

	logic                   accept;
	logic                   out_free;
	logic                   hit;
	logic                   last_cmp;

	assign bucket    = hash_q[HASH_W-1 -: BUCKET_BITS];
	assign key_word  = {1'b0, key_q};
	assign key_byte  = key_word[{round_q, 3'b000} +: 8];
	assign hash_mix  = HASH_W'((hash_q ^ {24'd0, key_byte}) * FNV_PRIME);
	assign fill_cur  = fill_valid_q[bucket] ? fill_rd : '0;
	assign last_slot = fill_q - FW'(1);
	assign total_ext = 32'(total_q);

	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign hit      = rd_valid_s1 && (ent_rdata[EW-1 -: KEY_W] == key_q);
	assign last_cmp = rd_valid_s1 && (rd_idx_s1 == last_slot);

	assign req.ready        = (state_q == ST_IDLE);
	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.found_handle = out_handle_q;
	assign rsp.entry_count  = out_count_q;

	assign ent_raddr = (state_q == ST_LAST_RD) ? {bucket, last_slot[SW-1:0]}
		: {bucket, scan_idx_q[SW-1:0]};

	always_comb begin
		state_d    = state_q;
		fill_we    = 1'b0;
		fill_wdata = fill_q;
		ent_we     = 1'b0;
		ent_waddr  = {bucket, fill_cur[SW-1:0]};
		ent_wdata  = {key_q, handle_q};
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_HASH;
				end
			end
			ST_HASH: begin
				if (round_q == 2'd3) begin
					state_d = ST_FILL_RD;
				end
			end
			ST_FILL_RD: begin
				state_d = ST_FILL;
			end
			ST_FILL: begin
				case (req_q)
					REQ_INSERT: begin
						state_d = ST_DONE;
						if (fill_cur < FW'(SLOTS_PER_BUCKET)) begin
							ent_we     = 1'b1;
							fill_we    = 1'b1;
							fill_wdata = fill_cur + FW'(1);
						end
					end
					REQ_FIND, REQ_REMOVE: begin
						state_d = (fill_cur == '0) ? ST_DONE : ST_SCAN;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_SCAN: begin
				if (hit) begin
					if (req_q == REQ_REMOVE) begin
						fill_we    = 1'b1;
						fill_wdata = last_slot;
						state_d    = (rd_idx_s1 == last_slot) ? ST_DONE : ST_LAST_RD;
					end else begin
						state_d = ST_DONE;
					end
				end else if (last_cmp) begin
					state_d = ST_DONE;
				end
			end
			ST_LAST_RD: begin
				state_d = ST_MOVE;
			end
			ST_MOVE: begin
				ent_we    = 1'b1;
				ent_waddr = {bucket, pos_q[SW-1:0]};
				ent_wdata = ent_rdata;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_valid_q <= '0;
			total_q      <= '0;
			out_valid_q  <= 1'b0;
			rd_valid_s1  <= 1'b0;
			round_q      <= '0;
		end else begin
			if (fill_we) begin
				fill_valid_q[bucket] <= 1'b1;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					round_q <= '0;
				end
				ST_HASH: begin
					round_q <= round_q + 2'd1;
				end
				ST_FILL: begin
					rd_valid_s1 <= 1'b0;
					if (req_q == REQ_INSERT && fill_we) begin
						total_q <= total_q + TW'(1);
					end
				end
				ST_SCAN: begin
					rd_valid_s1 <= (scan_idx_q < fill_q) && !hit && !last_cmp;
					if (hit && req_q == REQ_REMOVE) begin
						total_q <= total_q - TW'(1);
					end
				end
				default: begin
					rd_valid_s1 <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				req_q        <= req.req_type;
				key_q        <= req.conn_key;
				handle_q     <= req.conn_handle;
				hash_q       <= FNV_BASIS;
				res_status_q <= STATUS_MISS;
				res_handle_q <= '0;
			end
			ST_HASH: begin
				hash_q <= hash_mix;
			end
			ST_FILL: begin
				fill_q     <= fill_cur;
				scan_idx_q <= '0;
				if (req_q == REQ_INSERT) begin
					res_status_q <= fill_we ? STATUS_DONE : STATUS_FULL;
				end
			end
			ST_SCAN: begin
				rd_idx_s1 <= scan_idx_q;
				if (scan_idx_q < fill_q) begin
					scan_idx_q <= scan_idx_q + FW'(1);
				end
				if (hit) begin
					res_status_q <= STATUS_DONE;
					pos_q        <= rd_idx_s1;
					if (req_q == REQ_FIND) begin
						res_handle_q <= ent_rdata[HANDLE_W-1:0];
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_handle_q <= res_handle_q;
					out_count_q  <= total_ext[COUNT_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	bkht_ram #(
		.WIDTH(FW),
		.DEPTH(BUCKET_COUNT)
	) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (bucket),
		.wdata (fill_wdata),
		.raddr (bucket),
		.rdata (fill_rd)
	);

	bkht_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

endmodule

// File: tb/sv/bkht_table_checker.sv
// Checker that tracks the bucketed key/handle table and compares every response with it.
`timescale 1ns / 1ps
module bkht_table_checker import bkht_pkg::*; #(
	parameter int SLOTS_PER_BUCKET = SLOTS_PER_BUCKET_DEF
) (
	input  logic clk,
	input  logic arst_n,
	bkht_req_if  req,
	bkht_rsp_if  rsp,
	output int   mismatches,
	output int   outstanding
);

	localparam int TABLE_DEPTH = BUCKET_COUNT * SLOTS_PER_BUCKET;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] handle;
		logic [COUNT_W-1:0]  count;
	} answer_t;

	logic [KEY_W-1:0]    key_mem    [TABLE_DEPTH];
	logic [HANDLE_W-1:0] handle_mem [TABLE_DEPTH];
	int                  fill       [BUCKET_COUNT];
	int                  entries;
	int                  err_count;
	answer_t             answers    [$];
	answer_t             oldest;

	function automatic logic [BUCKET_BITS-1:0] bucket_of(input logic [KEY_W-1:0] key);
		logic [HASH_W-1:0] h;
		logic [31:0]       word;
		int                i;
		h = FNV_BASIS;
		word = {1'b0, key};
		for (i = 0; i < 4; i++) begin
			h = h ^ {24'd0, word[8*i +: 8]};
			h = h * FNV_PRIME;
		end
		return h[HASH_W-1 -: BUCKET_BITS];
	endfunction

	task automatic apply_request(input logic [REQ_W-1:0] kind, input logic [KEY_W-1:0] key,
		input logic [HANDLE_W-1:0] handle);
		int      bkt;
		int      base;
		int      pos;
		int      last;
		int      i;
		answer_t ans;
		bkt = bucket_of(key);
		base = bkt * SLOTS_PER_BUCKET;
		ans.status = STATUS_MISS;
		ans.handle = '0;
		pos = -1;
		for (i = 0; i < fill[bkt]; i++) begin
			if (pos < 0 && key_mem[base+i] == key)
				pos = i;
		end
		case (kind)
			REQ_INSERT: begin
				if (fill[bkt] >= SLOTS_PER_BUCKET) begin
					ans.status = STATUS_FULL;
				end else begin
					key_mem[base+fill[bkt]] = key;
					handle_mem[base+fill[bkt]] = handle;
					fill[bkt]++;
					entries++;
					ans.status = STATUS_DONE;
				end
			end
			REQ_FIND: begin
				if (pos >= 0) begin
					ans.status = STATUS_DONE;
					ans.handle = handle_mem[base+pos];
				end
			end
			REQ_REMOVE: begin
				if (pos >= 0) begin
					// The last entry of the bucket fills the hole left by the removed one.
					last = fill[bkt] - 1;
					key_mem[base+pos] = key_mem[base+last];
					handle_mem[base+pos] = handle_mem[base+last];
					fill[bkt] = last;
					entries--;
					ans.status = STATUS_DONE;
				end
			end
			default: begin
			end
		endcase
		ans.count = COUNT_W'(entries);
		answers.push_back(ans);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < BUCKET_COUNT; b++)
				fill[b] = 0;
			entries = 0;
			err_count = 0;
			answers.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (req.valid === 1'b1 && req.ready === 1'b1)
				apply_request(req.req_type, req.conn_key, req.conn_handle);
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				if (answers.size() == 0) begin
					$error("response with no request outstanding");
					err_count++;
				end else begin
					oldest = answers.pop_front();
					if (rsp.status !== oldest.status) begin
						$error("status: expected %0d, got %0d", oldest.status, rsp.status);
						err_count++;
					end
					if (rsp.found_handle !== oldest.handle) begin
						$error("found_handle: expected %0d, got %0d", oldest.handle,
							rsp.found_handle);
						err_count++;
					end
					if (rsp.entry_count !== oldest.count) begin
						$error("entry_count: expected %0d, got %0d", oldest.count,
							rsp.entry_count);
						err_count++;
					end
				end
			end
			mismatches <= err_count;
			outstanding <= answers.size();
		end
	end

endmodule

// File: tb/sv/testbench.sv
// Top of the key/handle table testbench: clock, reset, request stimulus and response stalls.
`timescale 1ns / 1ps
module testbench;
	import bkht_pkg::*;

	localparam int                 SLOTS        = SLOTS_PER_BUCKET_DEF;
	localparam int                 TOTAL_ITEMS  = 1500;
	localparam int                 HOT_BUCKETS  = 6;
	localparam int                 HOT_KEYS     = 48;
	localparam int                 HOLD_CYCLES  = 400;
	localparam logic [REQ_W-1:0]   REQ_UNUSED   = 2'd3;
	localparam logic [KEY_W-1:0]   KEY_MAX      = {KEY_W{1'b1}};

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   sent;
	bit   no_idle;
	bit   hold_req;

	logic [KEY_W-1:0] hot_key [HOT_BUCKETS][HOT_KEYS];

	bkht_req_if req_ch ();
	bkht_rsp_if rsp_ch ();

	bucketed_key_handle_table #(.SLOTS_PER_BUCKET(SLOTS)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	bkht_table_checker #(.SLOTS_PER_BUCKET(SLOTS)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic int gap_len();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// The valid line is left high after a request so that the next one can follow at once.
	task automatic send(input logic [REQ_W-1:0] kind, input logic [KEY_W-1:0] key,
		input logic [HANDLE_W-1:0] handle);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.conn_key <= key;
		req_ch.conn_handle <= handle;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sent++;
	endtask

	task automatic send_noise();
		send(REQ_W'($urandom_range(0, 3)), KEY_W'($urandom), HANDLE_W'($urandom));
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);
	endtask

	initial begin : response_side
		int stall_left;
		int hold_left;
		rsp_ch.ready = 1'b0;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				rsp_ch.ready <= 1'b0;
				hold_left = HOLD_CYCLES;
				while (hold_left > 0) begin
					@(posedge clk);
					hold_left--;
				end
				hold_req = 1'b0;
			end else begin
				if (stall_left == 0)
					stall_left = gap_len();
				if (stall_left > 0) begin
					rsp_ch.ready <= 1'b0;
					stall_left--;
				end else begin
					rsp_ch.ready <= 1'b1;
				end
			end
		end
	end

	initial begin : request_side
		int                     h;
		int                     k;
		int                     n;
		int                     r;
		int                     round;
		int                     hb;
		logic [KEY_W-1:0]       cand;
		logic [BUCKET_BITS-1:0] target;
		logic [KEY_W-1:0]       key_a;
		logic [KEY_W-1:0]       key_b;
		logic [KEY_W-1:0]       key_c;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_INSERT;
		req_ch.conn_key = '0;
		req_ch.conn_handle = '0;
		sent = 0;
		no_idle = 1'b0;
		hold_req = 1'b0;

		// A few buckets get a pool of keys each, so that requests pile up in them.
		for (h = 0; h < HOT_BUCKETS; h++) begin
			target = BUCKET_BITS'($urandom);
			for (k = 0; k < HOT_KEYS; k++) begin
				do cand = KEY_W'($urandom); while (u_checker.bucket_of(cand) != target);
				hot_key[h][k] = cand;
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(REQ_FIND, '0, 16'hFFFF);
		send(REQ_REMOVE, '0, '0);
		send(REQ_INSERT, '0, 16'hFFFF);
		send(REQ_INSERT, KEY_MAX, '0);
		send(REQ_FIND, '0, '0);
		send(REQ_FIND, KEY_MAX, 16'hFFFF);
		send(REQ_INSERT, '0, 16'h1234);
		send(REQ_FIND, '0, '0);
		send(REQ_REMOVE, '0, '0);
		send(REQ_FIND, '0, '0);
		send(REQ_UNUSED, KEY_MAX, 16'hFFFF);
		send(REQ_REMOVE, KEY_MAX, '0);
		send(REQ_FIND, KEY_MAX, '0);
		send(REQ_REMOVE, '0, '0);

		// Three keys in one bucket: removing the first pulls the last one forward.
		key_a = hot_key[0][0];
		key_b = hot_key[0][1];
		key_c = hot_key[0][2];
		send(REQ_INSERT, key_a, 16'h0A0A);
		send(REQ_INSERT, key_b, 16'h0B0B);
		send(REQ_INSERT, key_c, 16'h0C0C);
		send(REQ_REMOVE, key_a, '0);
		send(REQ_FIND, key_c, '0);
		send(REQ_FIND, key_b, '0);
		send(REQ_FIND, key_a, '0);
		send(REQ_REMOVE, key_c, '0);
		send(REQ_REMOVE, key_b, '0);

		round = 0;
		while (sent < TOTAL_ITEMS) begin
			no_idle = (round % 5 == 1);
			if (round == 2)
				hold_req = 1'b1;
			if (round % 6 == 4)
				settle();
			hb = $urandom_range(0, HOT_BUCKETS - 1);
			n = (round % 3 == 0) ? $urandom_range(34, 44) : $urandom_range(4, 24);
			repeat (n) begin
				if ($urandom_range(0, 9) == 0)
					send_noise();
				else
					send(REQ_INSERT, hot_key[hb][$urandom_range(0, 23)], HANDLE_W'($urandom));
			end
			n = $urandom_range(4, 40);
			repeat (n) begin
				r = $urandom_range(0, 99);
				if (r < 10)
					send_noise();
				else if (r < 55)
					send(REQ_FIND, hot_key[hb][$urandom_range(0, 27)], HANDLE_W'($urandom));
				else
					send(REQ_REMOVE, hot_key[hb][$urandom_range(0, 27)], HANDLE_W'($urandom));
			end
			round++;
		end

		no_idle = 1'b0;
		settle();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: files.f
design/bkht_pkg.sv
design/bkht_req_if.sv
design/bkht_rsp_if.sv
design/bkht_ram.sv
design/bucketed_key_handle_table.sv
tb/sv/bkht_table_checker.sv
tb/sv/testbench.sv
